FILE: src/ebd_pkg.sv
// shared types and constants of the energy beat detector
package ebd_pkg;

    localparam int SMP_W    = 16;
    localparam int E_W      = 48;
    localparam int P_W      = 17;
    localparam int SENS_W   = 12;
    localparam int DIG_W    = 24;
    localparam int SH_W     = 3;
    localparam int E2_DIG   = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [P_W-1:0] P_ONE = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_SENS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 1'b1;

    // one operation of the shared multiply-accumulate unit
    typedef struct packed {
        logic             vld;
        logic             clr;
        logic [DIG_W-1:0] a;
        logic [DIG_W-1:0] b;
        logic [SH_W-1:0]  sh;
    } t_mac_op;

endpackage

FILE: src/ebd_hist.sv
// ring history memory of block energies, one write and one registered read port
module ebd_hist #(
    parameter int DEPTH = 43,
    parameter int W     = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

FILE: src/ebd_mac.sv
// shared 24x24 multiplier with registered product and shifted wide accumulator
module ebd_mac import ebd_pkg::*; #(
    parameter int AW = 130
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mac_op       i_op,
    output logic [AW-1:0] o_acc
);

    logic [2*DIG_W-1:0] r_p;
    logic [SH_W-1:0]    r_sh;
    logic               r_v;
    logic               r_clr;
    logic [AW-1:0]      r_acc;
    logic [AW-1:0]      w_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_op.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p   <= i_op.a * i_op.b;
        r_sh  <= i_op.sh;
        r_clr <= i_op.clr;
    end

    // partial product placed at its digit position
    assign w_add = AW'(r_p) << (DIG_W * r_sh);

    always_ff @(posedge i_clk) begin
        if (r_v) begin
            r_acc <= (r_clr ? '0 : r_acc) + w_add;
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: src/energy_beat_detector_top.sv
// energy beat detector: sample energy, history walk and beat decision
//
// channel  direction  handshake                 payload
// s        in         i_s_tvalid / o_s_tready   i_s_tdata sample, i_s_tlast block end
// m        out        o_m_tvalid / i_m_tready   o_m_tdata beat, power_level, block_energy
// cfg      in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a sample without block end goes through the shared multiplier in IDLE, WAIT and SQF
// a block end runs four 24x24 products per history entry
// plus the threshold and energy products, all through the one multiplier
// after reset a clearing pass writes zero to every history entry before s opens
// a waiting result holds a block end in its decision step until o_m is free
module energy_beat_detector_top import ebd_pkg::*; #(
    parameter int HISTORY_DEPTH = 43
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [SMP_W-1:0]     i_s_tdata,   // [15:0] sample
    input  logic                 i_s_tlast,   // block end
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [71:0]          o_m_tdata,   // [0] beat, [17:1] power_level, [65:18] block_energy
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [P_W-1:0]       i_cfg_data
);

    localparam int IW = $clog2(HISTORY_DEPTH);
    localparam int SW = 2 * E_W + $clog2(HISTORY_DEPTH);
    localparam int AW = SW + DIG_W;
    localparam int ND = (SW + DIG_W - 1) / DIG_W;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_WAIT = 4'd2;
    localparam logic [3:0] ST_SQF  = 4'd3;
    localparam logic [3:0] ST_RD   = 4'd4;
    localparam logic [3:0] ST_SM   = 4'd5;
    localparam logic [3:0] ST_KS   = 4'd6;
    localparam logic [3:0] ST_KF   = 4'd7;
    localparam logic [3:0] ST_RM   = 4'd8;
    localparam logic [3:0] ST_RF   = 4'd9;
    localparam logic [3:0] ST_EM   = 4'd10;
    localparam logic [3:0] ST_EF   = 4'd11;
    localparam logic [3:0] ST_LM   = 4'd12;
    localparam logic [3:0] ST_CMP  = 4'd13;

    logic [3:0]        r_state, n_state;
    logic [3:0]        r_ret, n_ret;
    logic [IW-1:0]     r_idx, n_idx;
    logic [1:0]        r_j, n_j;
    logic [SH_W-1:0]   r_d, n_d;
    logic [IW-1:0]     r_wpos, n_wpos;
    logic              r_last, n_last;
    logic [E_W-1:0]    r_eacc, n_eacc;
    logic [E_W-1:0]    r_e, n_e;
    logic [SW-1:0]     r_opnd, n_opnd;
    logic [DIG_W-1:0]  r_k, n_k;
    logic [AW-1:0]     r_rhs, n_rhs;
    logic [P_W-1:0]    r_power, n_power;
    logic [SENS_W-1:0] r_sens;
    logic [P_W-1:0]    r_decay;
    logic              r_ovalid, n_ovalid;
    logic              r_obeat, n_obeat;
    logic [P_W-1:0]    r_opow, n_opow;
    logic [E_W-1:0]    r_oen, n_oen;

    t_mac_op           w_op;
    logic [AW-1:0]     w_acc;
    logic [E_W-1:0]    w_q;
    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [E_W-1:0]    w_wdata;
    logic              w_re;
    logic [IW-1:0]     w_raddr;
    logic [SMP_W-1:0]  w_mag;
    logic [E_W:0]      w_esum;
    logic [E_W-1:0]    w_e;
    logic [ND*DIG_W-1:0] w_opnd_pad;
    logic [DIG_W-1:0]  w_opnd_dig;
    logic              w_beat;
    logic [P_W-1:0]    w_pset;
    logic              w_accept;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;

    assign w_mag = i_s_tdata[SMP_W-1] ? SMP_W'(-i_s_tdata) : i_s_tdata;

    // block energy with saturation at all ones
    assign w_esum = {1'b0, r_eacc} + (E_W + 1)'(w_acc[2*SMP_W-1:0]);
    assign w_e    = w_esum[E_W] ? '1 : w_esum[E_W-1:0];

    assign w_opnd_pad = (ND*DIG_W)'(r_opnd);
    assign w_opnd_dig = w_opnd_pad[r_d*DIG_W +: DIG_W];

    // lhs is E^2 * depth in the accumulator, scaled by 2^16 here
    assign w_beat = {w_acc[AW-17:0], 16'd0} > r_rhs;
    assign w_pset = w_beat ? P_ONE : r_power;

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_idx    = r_idx;
        n_j      = r_j;
        n_d      = r_d;
        n_wpos   = r_wpos;
        n_last   = r_last;
        n_eacc   = r_eacc;
        n_e      = r_e;
        n_opnd   = r_opnd;
        n_k      = r_k;
        n_rhs    = r_rhs;
        n_power  = r_power;
        n_ovalid = r_ovalid && !i_m_tready;
        n_obeat  = r_obeat;
        n_opow   = r_opow;
        n_oen    = r_oen;
        w_op     = '0;
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wdata  = '0;
        w_re     = 1'b0;
        w_raddr  = r_idx;

        case (r_state)
            ST_CLR: begin
                w_we = 1'b1;
                if (r_idx == IW'(HISTORY_DEPTH - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    w_op.vld = 1'b1;
                    w_op.clr = 1'b1;
                    w_op.a   = DIG_W'(w_mag);
                    w_op.b   = DIG_W'(w_mag);
                    n_last   = i_s_tlast;
                    n_ret    = ST_SQF;
                    n_state  = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_state = r_ret;
            end
            ST_SQF: begin
                if (!r_last) begin
                    n_eacc  = w_e;
                    n_state = ST_IDLE;
                end else begin
                    n_eacc  = '0;
                    n_e     = w_e;
                    n_wpos  = (r_wpos == IW'(HISTORY_DEPTH - 1)) ? '0 : r_wpos + 1'b1;
                    w_we    = 1'b1;
                    w_waddr = n_wpos;
                    w_wdata = w_e;
                    n_idx   = '0;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                w_re    = 1'b1;
                n_j     = '0;
                n_state = ST_SM;
            end
            ST_SM: begin
                // h^2 as lo*lo + 2^24*(lo*hi + hi*lo) + 2^48*hi*hi
                w_op.vld = 1'b1;
                w_op.clr = (r_idx == '0) && (r_j == 2'd0);
                w_op.a   = r_j[1] ? w_q[E_W-1:DIG_W] : w_q[DIG_W-1:0];
                w_op.b   = (r_j == 2'd0 || r_j == 2'd2) ? w_q[DIG_W-1:0] : w_q[E_W-1:DIG_W];
                w_op.sh  = (r_j == 2'd0) ? SH_W'(0) : ((r_j == 2'd3) ? SH_W'(2) : SH_W'(1));
                n_j      = r_j + 1'b1;
                if (r_j == 2'd3) begin
                    if (r_idx == IW'(HISTORY_DEPTH - 1)) begin
                        n_ret   = ST_KS;
                        n_state = ST_WAIT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        w_re    = 1'b1;
                        w_raddr = r_idx + 1'b1;
                    end
                end
            end
            ST_KS: begin
                n_opnd   = w_acc[SW-1:0];
                w_op.vld = 1'b1;
                w_op.clr = 1'b1;
                w_op.a   = DIG_W'(r_sens);
                w_op.b   = DIG_W'(r_sens);
                n_ret    = ST_KF;
                n_state  = ST_WAIT;
            end
            ST_KF: begin
                n_k     = w_acc[DIG_W-1:0];
                n_d     = '0;
                n_state = ST_RM;
            end
            ST_RM: begin
                w_op.vld = 1'b1;
                w_op.clr = (r_d == '0);
                w_op.a   = w_opnd_dig;
                w_op.b   = r_k;
                w_op.sh  = r_d;
                if (r_d == SH_W'(ND - 1)) begin
                    n_ret   = ST_RF;
                    n_state = ST_WAIT;
                end else begin
                    n_d = r_d + 1'b1;
                end
            end
            ST_RF: begin
                n_rhs   = w_acc;
                n_j     = '0;
                n_state = ST_EM;
            end
            ST_EM: begin
                w_op.vld = 1'b1;
                w_op.clr = (r_j == 2'd0);
                w_op.a   = r_j[1] ? r_e[E_W-1:DIG_W] : r_e[DIG_W-1:0];
                w_op.b   = (r_j == 2'd0 || r_j == 2'd2) ? r_e[DIG_W-1:0] : r_e[E_W-1:DIG_W];
                w_op.sh  = (r_j == 2'd0) ? SH_W'(0) : ((r_j == 2'd3) ? SH_W'(2) : SH_W'(1));
                n_j      = r_j + 1'b1;
                if (r_j == 2'd3) begin
                    n_ret   = ST_EF;
                    n_state = ST_WAIT;
                end
            end
            ST_EF: begin
                n_opnd  = SW'(w_acc[2*E_W-1:0]);
                n_d     = '0;
                n_state = ST_LM;
            end
            ST_LM: begin
                w_op.vld = 1'b1;
                w_op.clr = (r_d == '0);
                w_op.a   = w_opnd_dig;
                w_op.b   = DIG_W'(HISTORY_DEPTH);
                w_op.sh  = r_d;
                if (r_d == SH_W'(E2_DIG - 1)) begin
                    n_ret   = ST_CMP;
                    n_state = ST_WAIT;
                end else begin
                    n_d = r_d + 1'b1;
                end
            end
            ST_CMP: begin
                if (!r_ovalid || i_m_tready) begin
                    n_power  = (w_pset > r_decay) ? w_pset - r_decay : '0;
                    n_obeat  = w_beat;
                    n_opow   = n_power;
                    n_oen    = r_e;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_ret    <= ST_IDLE;
            r_idx    <= '0;
            r_j      <= '0;
            r_d      <= '0;
            r_wpos   <= '0;
            r_last   <= 1'b0;
            r_eacc   <= '0;
            r_power  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_idx    <= n_idx;
            r_j      <= n_j;
            r_d      <= n_d;
            r_wpos   <= n_wpos;
            r_last   <= n_last;
            r_eacc   <= n_eacc;
            r_power  <= n_power;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e     <= n_e;
        r_opnd  <= n_opnd;
        r_k     <= n_k;
        r_rhs   <= n_rhs;
        r_obeat <= n_obeat;
        r_opow  <= n_opow;
        r_oen   <= n_oen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens  <= SENS_W'(435);
            r_decay <= P_W'(4096);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SENS:  r_sens  <= i_cfg_data[SENS_W-1:0];
                CFG_DECAY: r_decay <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ebd_mac #(
        .AW (AW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .o_acc   (w_acc)
    );

    ebd_hist #(
        .DEPTH (HISTORY_DEPTH),
        .W     (E_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'd0, r_oen, r_opow, r_obeat};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted on back-to-back cycles");

    a_power_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_power <= P_ONE)
        else $error("power above one");

    a_result_from_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ST_CMP)
        else $error("result raised outside the decision step");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx <= IW'(HISTORY_DEPTH - 1)) && (r_wpos <= IW'(HISTORY_DEPTH - 1)))
        else $error("history index out of range");
`endif

endmodule

FILE: test/energy_beat_detector_top_tb.sv
// testbench for energy_beat_detector_top: random audio blocks against a predictor
`timescale 1ns / 1ps

module energy_beat_detector_top_tb;
    import ebd_pkg::*;

    localparam int HIST         = 43;
    localparam int BLOCK_CYCLES = 4 * HIST + 27 + 16;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 240;

    typedef struct packed {
        logic           beat;
        logic [P_W-1:0] power;
        logic [E_W-1:0] energy;
    } t_beat_result;

    class beat_scoreboard;
        logic [E_W-1:0]    history [HIST];
        int unsigned       wr_pos;
        logic [E_W-1:0]    acc;
        logic [P_W-1:0]    power;
        logic [SENS_W-1:0] sens;
        logic [P_W-1:0]    decay;
        t_beat_result      blocks_due [$];
        int                errors;

        function new();
            foreach (history[i]) history[i] = '0;
            wr_pos = 0;
            acc    = '0;
            power  = '0;
            sens   = 12'd435;
            decay  = 17'd4096;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [P_W-1:0] d);
            case (idx)
                CFG_SENS:  sens  = d[SENS_W-1:0];
                CFG_DECAY: decay = d;
                default:   ;
            endcase
        endfunction

        // adds one sample; a block end yields the expected result of the block
        function void take_sample(logic [SMP_W-1:0] smp, logic last);
            logic signed [SMP_W-1:0] s;
            logic [31:0]             sq;
            logic [E_W:0]            e;
            logic [159:0]            hist_sum;
            logic [159:0]            lhs;
            t_beat_result            r;
            s  = smp;
            sq = int'(s) * int'(s);
            e  = {1'b0, acc} + sq;
            if (e[E_W]) e[E_W-1:0] = '1;
            if (!last) begin
                acc = e[E_W-1:0];
                return;
            end
            acc = '0;
            wr_pos = (wr_pos + 1) % HIST;
            history[wr_pos] = e[E_W-1:0];
            hist_sum = '0;
            foreach (history[i])
                hist_sum = hist_sum + {112'd0, history[i]} * {112'd0, history[i]};
            hist_sum = hist_sum * {148'd0, sens} * {148'd0, sens};
            lhs = {112'd0, e[E_W-1:0]};
            lhs = lhs * lhs * 160'(HIST * 65536);
            r.beat = (lhs > hist_sum);
            if (r.beat) power = P_ONE;
            if (power != '0) power = (power > decay) ? power - decay : '0;
            r.power  = power;
            r.energy = e[E_W-1:0];
            blocks_due.push_back(r);
        endfunction

        task report(string msg);
            $display("error at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_block(logic [71:0] d);
            t_beat_result want;
            if (blocks_due.size() == 0) begin
                report($sformatf("result %h with none expected", d));
                return;
            end
            want = blocks_due.pop_front();
            if (d[0] !== want.beat)
                report($sformatf("beat %b, expected %b", d[0], want.beat));
            if (d[17:1] !== want.power)
                report($sformatf("power_level %0d, expected %0d", d[17:1], want.power));
            if (d[65:18] !== want.energy)
                report($sformatf("block_energy %0d, expected %0d", d[65:18], want.energy));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [SMP_W-1:0]     i_s_tdata;
    logic                 i_s_tlast;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [71:0]          o_m_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [P_W-1:0]       i_cfg_data;

    beat_scoreboard sb = new();
    bit             calm;
    int             idle_pct;
    int             hold_left;
    int             cycles;

    energy_beat_detector_top #(.HISTORY_DEPTH(HIST)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.take_sample(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) sb.check_block(o_m_tdata);
            if (i_cfg_valid && o_cfg_ready) sb.set_reg(i_cfg_index, i_cfg_data);
        end
    end

    // receiver: random stall bursts, a long hold-off on request, always ready when calm
    initial begin
        int gap;
        gap = 0;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else if (calm) begin
                i_m_tready <= 1'b1;
            end else if (gap > 0) begin
                i_m_tready <= 1'b0;
                gap--;
            end else begin
                i_m_tready <= 1'b1;
                if ($urandom_range(0, 4) == 0) gap = $urandom_range(1, 8);
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("energy_beat_detector_top: mismatch");
        $finish;
    end

    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= SMP_W'($urandom);
            i_s_tlast  <= 1'($urandom);
        end
    endtask

    task automatic send_sample(input logic [SMP_W-1:0] smp, input logic last);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= smp;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        if (!calm && $urandom_range(0, 99) < idle_pct) idle_sender($urandom_range(1, 8));
    endtask

    // lets every expected result arrive, then covers a block end still in flight
    task automatic drain();
        idle_sender(1);
        while (sb.blocks_due.size() != 0) @(posedge i_clk);
        repeat (BLOCK_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [P_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [SMP_W-1:0] rand_sample(input int shift);
        logic signed [SMP_W-1:0] v;
        v = SMP_W'($urandom);
        v = v >>> shift;
        if ($urandom_range(0, 31) == 0) v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        return v;
    endfunction

    // blocks of random length and loudness, so history energies span a wide range
    task automatic random_blocks(input int n_items);
        int sent;
        int len;
        int shift;
        sent = 0;
        while (sent < n_items) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            shift = $urandom_range(0, 15);
            for (int k = 0; k < len; k++) send_sample(rand_sample(shift), k == len - 1);
            sent += len;
        end
    endtask

    initial begin
        logic [SENS_W-1:0] sens_set  [PHASES];
        logic [P_W-1:0]    decay_set [PHASES];
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SENS;
        i_cfg_data  = '0;
        calm        = 1'b0;
        idle_pct    = 20;
        hold_left   = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_SENS, 17'd435);
        write_reg(CFG_DECAY, 17'd4096);

        // silent block on an empty history must not beat, then blocks of edge-value samples
        send_sample(16'h0000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b1);
        send_sample(16'h8000, 1'b1);
        drain();

        // zero sensitivity: silence still no beat, any energy beats
        write_reg(CFG_SENS, 17'd0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0001, 1'b1);
        drain();

        // decay step above one drives the power straight to zero
        write_reg(CFG_DECAY, 17'h1FFFF);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0000, 1'b1);
        drain();

        sens_set  = '{12'd435, 12'd0, 12'd4095, 12'd1, 12'($urandom_range(1, 4095)),
                      12'd256, 12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095))};
        decay_set = '{17'd4096, 17'd65536, 17'd0, 17'h1FFFF, 17'($urandom_range(0, 65536)),
                      17'd1, 17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536))};
        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_SENS, {5'd0, sens_set[p]});
            write_reg(CFG_DECAY, decay_set[p]);
            idle_pct = $urandom_range(5, 35);
            calm = (p == PHASES - 1);
            // long receiver hold-off so results back up and the input stalls
            if (p == 1) hold_left = 3000;
            random_blocks(PHASE_ITEMS);
            drain();
        end

        if (sb.blocks_due.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.blocks_due.size()));
        if (sb.errors == 0)
            $display("energy_beat_detector_top: match");
        else
            $display("energy_beat_detector_top: mismatch");
        $finish;
    end

endmodule
